FILE: src/arss_pkg.sv
// Shared widths, constants and controller/datapath handshake types for the scaler.
`default_nettype none
package arss_pkg;

  // Field widths of the sample and result beats.
  localparam int CH_W     = 3;
  localparam int SAMPLE_W = 10;
  localparam int SCALED_W = 10;

  // Configuration port layout.
  localparam int CFG_W     = 9;
  localparam int CFG_IDX_W = 1;
  localparam int FACTOR_W  = 9;
  localparam int MASK_W    = 8;

  // Register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_SMOOTHING = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INVERT    = 1'd1;

  // Reset values of the registers.
  localparam logic [FACTOR_W-1:0] FACTOR_RESET = 9'd64;
  localparam logic [MASK_W-1:0]   MASK_RESET   = 8'd0;

  // Smoothed value is unsigned Q10.8.
  localparam int SMOOTH_W = 18;

  // Scale and range constants.
  localparam logic [SCALED_W-1:0] FULL_SCALE = 10'd1000;
  localparam logic [SAMPLE_W-1:0] RAW_TOP    = 10'd1023;
  localparam logic [SMOOTH_W-1:0] SMOOTH_TOP = {RAW_TOP, 8'd0};

  // The quotient is below 1024, so it has ten bits and the divider takes one bit a cycle.
  localparam int DIV_STEPS = 10;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic idle;
    logic load;
    logic mulb;
    logic blend;
    logic scale;
    logic div_step;
    logic finish;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic in_valid;
    logic out_free;
  } sts_t;

endpackage
`default_nettype wire

FILE: src/arss_if.sv
// Valid/ready channel interfaces for sample beats and result beats.
`default_nettype none
interface arss_in_if;
  logic                          valid;
  logic                          ready;
  logic [arss_pkg::CH_W-1:0]     channel;
  logic [arss_pkg::SAMPLE_W-1:0] sample;

  modport source(output valid, output channel, output sample, input ready);
  modport sink(input valid, input channel, input sample, output ready);
endinterface

interface arss_out_if;
  logic                          valid;
  logic                          ready;
  logic [arss_pkg::CH_W-1:0]     channel_out;
  logic [arss_pkg::SCALED_W-1:0] scaled;

  modport source(output valid, output channel_out, output scaled, input ready);
  modport sink(input valid, input channel_out, input scaled, output ready);
endinterface
`default_nettype wire

FILE: src/arss_ctrl.sv
// Sequencing state machine that steps the datapath through one sample.
`default_nettype none
module arss_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  arss_pkg::sts_t sts,
  output arss_pkg::cmd_t cmd
);
  import arss_pkg::*;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_LOAD   = 3'd1;
  localparam logic [2:0] ST_MULB   = 3'd2;
  localparam logic [2:0] ST_BLEND  = 3'd3;
  localparam logic [2:0] ST_SCALE  = 3'd4;
  localparam logic [2:0] ST_DIV    = 3'd5;
  localparam logic [2:0] ST_FINISH = 3'd6;

  localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(DIV_STEPS - 1);

  logic [2:0]           state;
  logic [2:0]           state_next;
  logic [DIV_CNT_W-1:0] cnt;
  logic [DIV_CNT_W-1:0] cnt_next;

  // Next-state logic.
  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    case (state)
      ST_IDLE: begin
        if (sts.in_valid) begin
          state_next = ST_LOAD;
        end
      end
      ST_LOAD:  state_next = ST_MULB;
      ST_MULB:  state_next = ST_BLEND;
      ST_BLEND: state_next = ST_SCALE;
      ST_SCALE: begin
        state_next = ST_DIV;
        cnt_next   = '0;
      end
      ST_DIV: begin
        cnt_next = cnt + 1'b1;
        if (cnt == DIV_LAST) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (sts.out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  // Command decode.
  always_comb begin
    cmd.idle     = (state == ST_IDLE);
    cmd.load     = (state == ST_LOAD);
    cmd.mulb     = (state == ST_MULB);
    cmd.blend    = (state == ST_BLEND);
    cmd.scale    = (state == ST_SCALE);
    cmd.div_step = (state == ST_DIV);
    cmd.finish   = (state == ST_FINISH) && sts.out_free;
  end

  // The divider never runs past its last step.
  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV) |-> (cnt <= DIV_LAST))
    else $error("divider step count out of range");

  // A result is only written when the output register can take it.
  a_finish_free: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |-> sts.out_free)
    else $error("result written over a waiting beat");

  // After the last divider step the sequence always reaches the finish state.
  a_div_to_finish: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV && cnt == DIV_LAST) |=> (state == ST_FINISH))
    else $error("divider did not hand over to finish");

endmodule
`default_nettype wire

FILE: src/arss_datapath.sv
// Per-channel state, smoothing arithmetic, span divider and output register.
`default_nettype none
module arss_datapath #(
  parameter int CHANNELS = 8
) (
  input  logic                             clk,
  input  logic                             rst,
  arss_in_if.sink                          samples,
  arss_out_if.source                       results,
  input  logic                             cfg_we,
  input  logic [arss_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [arss_pkg::CFG_W-1:0]       cfg_data,
  input  arss_pkg::cmd_t                   cmd,
  output arss_pkg::sts_t                   sts
);
  import arss_pkg::*;

  // Only channels reachable through the channel field need storage.
  localparam int MAX_CH = 1 << CH_W;
  localparam int DEPTH  = (CHANNELS < MAX_CH) ? CHANNELS : MAX_CH;
  localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [FACTOR_W-1:0] smoothing_factor;
  logic [MASK_W-1:0]   invert_mask;

  logic [SAMPLE_W-1:0] ch_min [DEPTH];
  logic [SAMPLE_W-1:0] ch_max [DEPTH];
  logic [SMOOTH_W-1:0] smooth [DEPTH];

  logic [CH_W-1:0]     ch_q;
  logic [SAMPLE_W-1:0] s_q;
  logic [SAMPLE_W-1:0] lo;
  logic [SAMPLE_W-1:0] hi;
  logic [SMOOTH_W-1:0] v_old;
  logic [FACTOR_W-1:0] a_q;
  logic [18:0]         p1;
  logic [26:0]         p2;
  logic [SMOOTH_W-1:0] v_new;
  logic [SAMPLE_W-1:0] rem;
  logic [SAMPLE_W-1:0] quo;
  logic [SAMPLE_W-1:0] dvs;
  logic                zero_f;
  logic                full_f;
  logic                out_valid;
  logic [CH_W-1:0]     out_ch;
  logic [SCALED_W-1:0] out_scaled;

  logic                capture;
  logic                ch_ok;
  logic [IDX_W-1:0]    idx;
  logic [FACTOR_W-1:0] a_eff;
  logic [SAMPLE_W-1:0] lo_new;
  logic [SAMPLE_W-1:0] hi_new;
  logic [27:0]         blend_sum;
  logic [19:0]         v_calc;
  logic [SMOOTH_W-1:0] v_clamp;
  logic [18:0]         r_sum;
  logic [10:0]         r;
  logic [SAMPLE_W-1:0] diff;
  logic [19:0]         num;
  logic [10:0]         shifted;
  logic [11:0]         trial;
  logic [SCALED_W-1:0] mapped;
  logic [SCALED_W-1:0] result;

  // Handshake and status.
  assign capture          = samples.valid && cmd.idle;
  assign samples.ready    = cmd.idle;
  assign sts.in_valid     = samples.valid;
  assign sts.out_free     = !out_valid || results.ready;
  assign results.valid       = out_valid;
  assign results.channel_out = out_ch;
  assign results.scaled      = out_scaled;

  // Channel decode.
  assign ch_ok = (32'(ch_q) < CHANNELS);
  assign idx   = IDX_W'(ch_q);

  // A factor of zero acts as one, anything at or above 256 as 256.
  always_comb begin
    if (smoothing_factor == '0) begin
      a_eff = FACTOR_W'(1);
    end else if (smoothing_factor[FACTOR_W-1]) begin
      a_eff = FACTOR_W'(256);
    end else begin
      a_eff = smoothing_factor;
    end
  end

  // Range update against the stored minimum and maximum.
  assign lo_new = (s_q < ch_min[idx]) ? s_q : ch_min[idx];
  assign hi_new = (s_q > ch_max[idx]) ? s_q : ch_max[idx];

  // Blend of the weighted sample and the weighted old value, rounded half up.
  assign blend_sum = {1'b0, p1, 8'd0} + {1'b0, p2} + 28'd128;
  assign v_calc    = blend_sum[27:8];
  assign v_clamp   = (v_calc > 20'(SMOOTH_TOP)) ? SMOOTH_TOP : v_calc[SMOOTH_W-1:0];

  // Integer part of the smoothed value, rounded half up.
  assign r_sum = {1'b0, v_new} + 19'd128;
  assign r     = r_sum[18:8];
  assign diff  = r[SAMPLE_W-1:0] - lo;
  assign num   = 20'(diff) * 20'(FULL_SCALE);

  // One restoring divider step.
  assign shifted = {rem, quo[SAMPLE_W-1]};
  assign trial   = {1'b0, shifted} - {2'b00, dvs};

  // Final mapping, inversion and out-of-range channel.
  always_comb begin
    if (zero_f) begin
      mapped = '0;
    end else if (full_f) begin
      mapped = FULL_SCALE;
    end else begin
      mapped = quo;
    end
    if (!ch_ok) begin
      result = '0;
    end else if (invert_mask[ch_q]) begin
      result = FULL_SCALE - mapped;
    end else begin
      result = mapped;
    end
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      smoothing_factor <= FACTOR_RESET;
      invert_mask      <= MASK_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SMOOTHING: smoothing_factor <= cfg_data;
        REG_INVERT:    invert_mask      <= cfg_data[MASK_W-1:0];
        default: ;
      endcase
    end
  end

  // Per-channel state, cleared by reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < DEPTH; i++) begin
        ch_min[i] <= RAW_TOP;
        ch_max[i] <= '0;
        smooth[i] <= '0;
      end
    end else begin
      if (cmd.load && ch_ok) begin
        ch_min[idx] <= lo_new;
        ch_max[idx] <= hi_new;
      end
      if (cmd.blend && ch_ok) begin
        smooth[idx] <= v_clamp;
      end
    end
  end

  // Working registers of the sequence.
  always_ff @(posedge clk) begin
    if (capture) begin
      ch_q <= samples.channel;
      s_q  <= samples.sample;
    end
    if (cmd.load) begin
      lo    <= lo_new;
      hi    <= hi_new;
      v_old <= smooth[idx];
      a_q   <= a_eff;
      p1    <= 19'(a_eff) * 19'(s_q);
    end
    if (cmd.mulb) begin
      p2 <= 27'(FACTOR_W'(256) - a_q) * 27'(v_old);
    end
    if (cmd.blend) begin
      v_new <= v_clamp;
    end
    if (cmd.scale) begin
      zero_f <= (hi <= lo) || (r <= 11'(lo));
      full_f <= (r >= 11'(hi));
      rem    <= num[19:10];
      quo    <= num[9:0];
      dvs    <= hi - lo;
    end
    if (cmd.div_step) begin
      if (!trial[11]) begin
        rem <= trial[SAMPLE_W-1:0];
        quo <= {quo[SAMPLE_W-2:0], 1'b1};
      end else begin
        rem <= shifted[SAMPLE_W-1:0];
        quo <= {quo[SAMPLE_W-2:0], 1'b0};
      end
    end
  end

  // Output register; holds the beat until it is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.finish) begin
      out_valid <= 1'b1;
    end else if (results.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_ch     <= ch_q;
      out_scaled <= result;
    end
  end

  // The scaled value stays within full scale.
  a_scaled_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_scaled <= FULL_SCALE))
    else $error("scaled value above full scale");

  // A finished item always shows up at the output.
  a_finish_out: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |=> out_valid)
    else $error("finished item not presented");

  // The stored smoothed value never leaves the converter range.
  a_smooth_range: assert property (@(posedge clk) disable iff (rst)
    (cmd.blend && ch_ok) |=> (smooth[idx] <= SMOOTH_TOP))
    else $error("smoothed value out of range");

endmodule
`default_nettype wire

FILE: src/auto_ranging_smoothing_scaler_unit.sv
// A result is registered in the output register at the finish step, after the load, multiply,
// blend and scale steps and the ten steps of the one-bit-a-cycle span divider; a new sample
// is accepted only once the sequencer is back in idle, after the finish step of the last one.
// A waiting result is held in the output register; a further sample is taken meanwhile,
// and its finish step waits only while that register is still full.
// Reset (rst, synchronous) clears all channel state at once; no clearing pass follows.
`default_nettype none
module auto_ranging_smoothing_scaler_unit #(
  parameter int CHANNELS = 8
) (
  input  logic                           clk,
  input  logic                           rst,
  arss_in_if.sink                        samples,
  arss_out_if.source                     results,
  input  logic                           cfg_we,
  input  logic [arss_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [arss_pkg::CFG_W-1:0]     cfg_data
);
  import arss_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // Sequencer.
  arss_ctrl u_ctrl (
    .clk (clk),
    .rst (rst),
    .sts (sts),
    .cmd (cmd)
  );

  // Arithmetic and storage.
  arss_datapath #(
    .CHANNELS (CHANNELS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .samples   (samples),
    .results   (results),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule
`default_nettype wire

FILE: tb/sv/arss_result_checker.sv
// Checker for the scaler: predicts every result beat from the sample beats and compares.
`default_nettype none
module arss_result_checker #(
  parameter int CHANNELS = 8
) (
  input  logic                           clk,
  input  logic                           rst,
  arss_in_if                             samples,
  arss_out_if                            results,
  input  logic                           cfg_we,
  input  logic [arss_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [arss_pkg::CFG_W-1:0]     cfg_data,
  output int                             failures,
  output int                             outstanding
);
  import arss_pkg::*;

  typedef struct packed {
    logic [CH_W-1:0]     channel;
    logic [SCALED_W-1:0] scaled;
  } scaled_beat_t;

  // Shadow copy of the registers and of the per-channel state.
  logic [FACTOR_W-1:0] factor_shadow;
  logic [MASK_W-1:0]   mask_shadow;
  logic [SAMPLE_W-1:0] chan_min    [CHANNELS];
  logic [SAMPLE_W-1:0] chan_max    [CHANNELS];
  logic [SMOOTH_W-1:0] chan_smooth [CHANNELS];

  scaled_beat_t pending_scaled [$];
  int           mismatch_total;

  // Widens the range, blends the sample into the smoothed value and maps it onto 0..1000.
  function automatic scaled_beat_t predict_scaled(input logic [CH_W-1:0] ch,
                                                  input logic [SAMPLE_W-1:0] raw);
    scaled_beat_t beat;
    int unsigned  weight;
    int unsigned  blend;
    int unsigned  rounded;
    int unsigned  lo;
    int unsigned  hi;
    int unsigned  mapped;
    beat.channel = ch;

    // A channel without storage leaves all state alone and reports zero.
    if (int'(ch) >= CHANNELS) begin
      beat.scaled = '0;
      return beat;
    end

    if (raw < chan_min[ch]) chan_min[ch] = raw;
    if (raw > chan_max[ch]) chan_max[ch] = raw;

    // A zero factor acts as the smallest weight, and anything past 256 as no smoothing.
    weight = 32'(factor_shadow);
    if (weight == 0) weight = 1;
    if (weight > 256) weight = 256;

    blend = weight * (int'(raw) << 8) + (256 - weight) * int'(chan_smooth[ch]) + 128;
    blend = blend >> 8;
    if (blend > int'(SMOOTH_TOP)) blend = 32'(SMOOTH_TOP);
    chan_smooth[ch] = blend[SMOOTH_W-1:0];
    rounded = (blend + 128) >> 8;

    // An empty span or a smoothed value at or below the minimum maps to zero.
    lo = 32'(chan_min[ch]);
    hi = 32'(chan_max[ch]);
    if (hi <= lo || rounded <= lo) mapped = 0;
    else if (rounded >= hi) mapped = 32'(FULL_SCALE);
    else mapped = ((rounded - lo) * 32'(FULL_SCALE)) / (hi - lo);
    if (mapped > 32'(FULL_SCALE)) mapped = 32'(FULL_SCALE);

    if (mask_shadow[ch]) mapped = 32'(FULL_SCALE) - mapped;
    beat.scaled = mapped[SCALED_W-1:0];
    return beat;
  endfunction

  // Register writes, result checks and predictions, all on the rising edge.
  always @(posedge clk) begin
    scaled_beat_t want;
    if (rst) begin
      factor_shadow = FACTOR_RESET;
      mask_shadow   = MASK_RESET;
      for (int c = 0; c < CHANNELS; c++) begin
        chan_min[c]    = RAW_TOP;
        chan_max[c]    = '0;
        chan_smooth[c] = '0;
      end
      pending_scaled.delete();
      mismatch_total = 0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == REG_SMOOTHING) factor_shadow = cfg_data[FACTOR_W-1:0];
        else if (cfg_index == REG_INVERT) mask_shadow = cfg_data[MASK_W-1:0];
      end

      // The result beat leaving now belongs to the oldest sample still waiting.
      if (results.valid && results.ready) begin
        if (pending_scaled.size() == 0) begin
          $display("%0t: unexpected result beat, channel %0d scaled %0d", $time,
                   results.channel_out, results.scaled);
          mismatch_total++;
        end else begin
          want = pending_scaled.pop_front();
          if (results.channel_out !== want.channel) begin
            $display("%0t: channel_out mismatch, expected %0d, actual %0d", $time,
                     want.channel, results.channel_out);
            mismatch_total++;
          end
          if (results.scaled !== want.scaled) begin
            $display("%0t: scaled mismatch on channel %0d, expected %0d, actual %0d", $time,
                     want.channel, want.scaled, results.scaled);
            mismatch_total++;
          end
        end
      end

      if (samples.valid && samples.ready)
        pending_scaled.push_back(predict_scaled(samples.channel, samples.sample));
    end
    failures    <= mismatch_total;
    outstanding <= pending_scaled.size();
  end

endmodule
`default_nettype wire

FILE: tb/sv/testbench.sv
// Top of the scaler testbench: clock, reset, sample stimulus, result back-pressure and verdict.
`default_nettype none
module testbench;
  import arss_pkg::*;

  localparam int LONG_HOLD      = 400;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int END_PAUSE      = 32;

  typedef enum int {PRESS_NONE, PRESS_HOLD, PRESS_PAUSE} pressure_t;

  logic                 clk;
  logic                 rst;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;

  bit tx_gaps;
  bit rx_stalls;
  bit hold_request;
  int idle_cycles = 0;
  int sent_count = 0;
  int settings_count = 0;
  int failures;
  int outstanding;

  arss_in_if  samples ();
  arss_out_if results ();

  auto_ranging_smoothing_scaler_unit #(.CHANNELS(8)) u_dut (
    .clk       (clk),
    .rst       (rst),
    .samples   (samples),
    .results   (results),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  arss_result_checker #(.CHANNELS(8)) u_checker (
    .clk         (clk),
    .rst         (rst),
    .samples     (samples),
    .results     (results),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .failures    (failures),
    .outstanding (outstanding)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // Watchdog: ends the run when no beat and no register write has happened for too long.
  always @(posedge clk) begin
    if (rst || (samples.valid && samples.ready) || (results.valid && results.ready) || cfg_we) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no beat for %0d cycles", $time, idle_cycles);
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  // Result side: ready in random bursts, with stalls and one long hold-off on request.
  initial begin
    results.ready = 1'b0;
    wait (rst == 1'b0);
    @(negedge clk);
    forever begin
      if (hold_request) begin
        results.ready = 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
        hold_request = 1'b0;
      end else if (rx_stalls && $urandom_range(0, 3) == 0) begin
        results.ready = 1'b0;
        repeat ($urandom_range(1, 13)) @(negedge clk);
      end else begin
        results.ready = 1'b1;
        repeat ($urandom_range(1, 24)) @(negedge clk);
      end
    end
  end

  // Offers one sample beat and returns at the falling edge after it is taken.
  // Valid stays high so that the next call can follow without a bubble.
  task automatic send_sample(input logic [CH_W-1:0] ch, input logic [SAMPLE_W-1:0] raw);
    if (tx_gaps && $urandom_range(0, 4) == 0) begin
      samples.valid = 1'b0;
      repeat ($urandom_range(1, 13)) @(negedge clk);
    end
    samples.valid   = 1'b1;
    samples.channel = ch;
    samples.sample  = raw;
    do @(posedge clk); while (!samples.ready);
    @(negedge clk);
    sent_count++;
  endtask

  // Stops offering samples and waits until every result beat has come back.
  task automatic drain();
    samples.valid = 1'b0;
    while (outstanding != 0) @(negedge clk);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    @(negedge clk);
    cfg_we    = 1'b0;
  endtask

  task automatic apply_setting(input logic [FACTOR_W-1:0] factor, input logic [MASK_W-1:0] mask);
    drain();
    write_register(REG_SMOOTHING, CFG_W'(factor));
    write_register(REG_INVERT, CFG_W'(mask));
    settings_count++;
  endtask

  // Random samples clustered round a per-channel centre; the spread sets how far the
  // running ranges grow, so narrow phases come first while the spans are still small.
  task automatic random_phase(input logic [FACTOR_W-1:0] factor, input logic [MASK_W-1:0] mask,
                              input int count, input int spread, input pressure_t pressure);
    int k;
    int ch;
    int value;
    apply_setting(factor, mask);
    if (pressure == PRESS_HOLD) hold_request = 1'b1;
    for (k = 0; k < count; k++) begin
      if (pressure == PRESS_PAUSE && k == count / 2) drain();
      ch = $urandom_range(0, 7);
      if (spread >= 1023 || (spread >= 256 && $urandom_range(0, 15) == 0)) begin
        value = $urandom_range(0, 1023);
      end else begin
        value = ch * 128 + 64 + int'($urandom_range(0, 2 * spread)) - spread;
        if (value < 0) value = 0;
        if (value > 1023) value = 1023;
      end
      send_sample(ch[CH_W-1:0], value[SAMPLE_W-1:0]);
    end
  endtask

  initial begin
    rst             = 1'b1;
    samples.valid   = 1'b0;
    samples.channel = '0;
    samples.sample  = '0;
    cfg_we          = 1'b0;
    cfg_index       = REG_SMOOTHING;
    cfg_data        = '0;
    tx_gaps         = 1'b1;
    rx_stalls       = 1'b1;
    hold_request    = 1'b0;
    repeat (8) @(negedge clk);
    rst = 1'b0;

    // No smoothing: empty spans, full-scale ends and inversion on the low channels.
    apply_setting(9'd256, 8'h0F);
    send_sample(3'd0, 10'd0);
    send_sample(3'd0, 10'd1023);
    send_sample(3'd0, 10'd512);
    send_sample(3'd4, 10'd1023);
    send_sample(3'd4, 10'd0);
    send_sample(3'd4, 10'd700);
    send_sample(3'd7, 10'd341);
    send_sample(3'd7, 10'd682);
    send_sample(3'd1, 10'd1023);

    // A zero factor: the smoothed value lags far below a fresh minimum.
    apply_setting(9'd0, 8'hF0);
    send_sample(3'd5, 10'd800);
    send_sample(3'd5, 10'd900);
    send_sample(3'd2, 10'd600);
    send_sample(3'd2, 10'd601);
    send_sample(3'd6, 10'd0);
    send_sample(3'd6, 10'd1023);
    send_sample(3'd6, 10'd1023);

    // A factor past 256 behaves as no smoothing.
    apply_setting(9'd511, 8'hAA);
    send_sample(3'd3, 10'd1023);
    send_sample(3'd3, 10'd0);
    send_sample(3'd3, 10'd300);
    send_sample(3'd1, 10'd0);
    send_sample(3'd1, 10'd512);

    random_phase(9'd1, 8'h00, 150, 4, PRESS_HOLD);
    random_phase(9'd32, 8'hFF, 200, 16, PRESS_PAUSE);
    random_phase(9'd128, MASK_W'($urandom), 200, 64, PRESS_NONE);
    random_phase(9'd300, 8'h55, 200, 256, PRESS_NONE);
    random_phase(FACTOR_W'($urandom_range(1, 256)), MASK_W'($urandom), 250, 1023, PRESS_NONE);

    // The closing stretch runs with no idling on either side.
    tx_gaps   = 1'b0;
    rx_stalls = 1'b0;
    random_phase(9'd256, MASK_W'($urandom), 250, 1023, PRESS_NONE);

    drain();
    repeat (END_PAUSE) @(posedge clk);

    $display("Sent %0d sample beats under %0d register settings, from narrow to full spans,",
             sent_count, settings_count);
    $display("with a long result hold-off, a sender drain pause and a final idle-free stretch.");
    if (outstanding != 0)
      $display("%0t: %0d expected result beats never arrived", $time, outstanding);
    if (failures == 0 && outstanding == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
`default_nettype wire
